// File: hdl/assert_macros.svh
// Assertion macros used by the checker of the tap tempo sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/tts_pkg.sv
// Types and constants shared by the tap tempo step sequencer modules.
package tts_pkg;

	localparam int TIME_W    = 40;
	localparam int ELAPSED_W = 20;
	localparam int STEP_W    = 4;
	localparam int SCENE_W   = 2;
	localparam int LEVEL_W   = 8;
	localparam int TEMPO_W   = 15;
	localparam int ACC_W     = 32;
	localparam int PAT_W     = 64;
	localparam int REG_IDX_W = 2;

	localparam int SEQ_STEPS   = 16;
	localparam int SCENE_COUNT = 3;

	localparam logic [TEMPO_W-1:0] TEMPO_MIN   = 15'd4500;
	localparam logic [TEMPO_W-1:0] TEMPO_MAX   = 15'd22000;
	localparam logic [TEMPO_W-1:0] TEMPO_RESET = 15'd12000;

	localparam logic [ACC_W-1:0] SCENE_PERIOD_RESET = 32'd8000000;

	// Step duration in microseconds is STEP_NUMER / tempo, below 2^19.
	localparam int DUR_W = 19;
	localparam logic [30:0] STEP_NUMER = 31'd1500000000;
	localparam logic [DUR_W-1:0] DUR_RESET = 19'd125000;

	// Tap interval window, exclusive on both ends.
	localparam logic [TIME_W-1:0] IVL_MIN = 40'd80000;
	localparam logic [TIME_W-1:0] IVL_MAX = 40'd2000000;

	// Tempo numerator grows by TAP_NUMER per valid interval.
	localparam int NUM_W = 37;
	localparam int SUM_W = 25;
	localparam logic [NUM_W-1:0] TAP_NUMER = 37'd6000000000;

	// Serial divider sizing. A tap quotient is below 2^17 because every valid
	// interval exceeds 80 ms; a step duration is below 2^19.
	localparam int DIV_DEN_W   = 25;
	localparam int DIV_LO_W    = 19;
	localparam int DIV_CNT_W   = 5;
	localparam int TAP_Q_BITS  = 17;
	localparam int DUR_Q_BITS  = 19;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_AUTO_EN  = 2'd0,
		REG_PERIOD   = 2'd1,
		REG_PAT_LOW  = 2'd2,
		REG_PAT_HIGH = 2'd3
	} tts_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_SCAN,
		ST_TDIV_GO,
		ST_TDIV_WAIT,
		ST_DDIV_GO,
		ST_DDIV_WAIT,
		ST_FINISH
	} tts_state_t;

	typedef struct packed {
		logic                 req_type;
		logic [ELAPSED_W-1:0] elapsed_us;
		logic [TIME_W-1:0]    tap_time_us;
	} tts_in_t;

	typedef struct packed {
		logic [STEP_W-1:0]  step_index;
		logic               step_moved;
		logic [LEVEL_W-1:0] glitch_level;
		logic [SCENE_W-1:0] scene_index;
		logic [TEMPO_W-1:0] tempo_x100;
		logic [TIME_W-1:0]  run_time_us;
	} tts_out_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] iters;
	} tts_div_req_t;

	typedef struct packed {
		logic busy;
		logic found;
	} tts_hist_sts_t;

endpackage

// File: hdl/tap_tempo_step_sequencer_top.sv
// Top level of the tap tempo step sequencer: control, step and scene logic.
// A tick walks the step loop for each step that it advances, then gives its result.
// A tap pushes its time and runs a one-interval-per-cycle scan; only when a valid
// interval is found does the bit-serial divider work out the tempo and after it
// the step duration. One item is in work at a time; the next transfer can be
// taken as soon as the block is idle again. Reset: 120 BPM.
module tap_tempo_step_sequencer_top
	import tts_pkg::*;
#(
	parameter int TAP_DEPTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  tts_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output tts_out_t             out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [PAT_W-1:0]     cfg_data
);

	// Configuration registers.
	logic             auto_en_q;
	logic [ACC_W-1:0] period_q;
	logic [PAT_W-1:0] pat_low_q;
	logic [PAT_W-1:0] pat_high_q;

	// Sequencer state.
	tts_state_t         state_q;
	tts_state_t         state_nxt;
	logic [TIME_W-1:0]  run_time_q;
	logic [ACC_W:0]     step_acc_q;
	logic [ACC_W-1:0]   scene_acc_q;
	logic [STEP_W-1:0]  step_q;
	logic               moved_q;
	logic [SCENE_W-1:0] scene_q;
	logic [LEVEL_W-1:0] level_q;
	logic [TEMPO_W-1:0] tempo_q;
	logic [DUR_W-1:0]   dur_q;

	// Result register.
	logic     out_valid_q;
	tts_out_t out_q;

	logic in_fire;
	logic out_free;
	logic hist_push;
	logic div_tap_mode;

	tts_div_req_t         div_req;
	logic                 div_busy;
	logic [DIV_LO_W-1:0]  div_quot;
	logic [DIV_DEN_W-1:0] div_rem_init;
	logic [DIV_LO_W-1:0]  div_lo_init;
	logic [DIV_DEN_W-1:0] div_den;

	tts_hist_sts_t    hist_sts;
	logic [NUM_W-1:0] hist_num;
	logic [SUM_W-1:0] hist_sum;
	logic [NUM_W-1:0] tap_num;

	logic [STEP_W-1:0]     step_nxt;
	logic [SCENE_W-1:0]    scene_nxt;
	logic [ACC_W:0]        scene_sum;
	logic                  step_due;
	logic [2*PAT_W-1:0]    pattern;
	logic [TEMPO_W-1:0]    tempo_den;
	logic [TAP_Q_BITS-1:0] tap_q;
	logic [TEMPO_W-1:0]    tempo_new;

	// Configuration writes are to be issued only while the block is idle; the
	// block itself does not enforce this. The port can always take them.
	assign cfg_ready = 1'b1;

	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign step_nxt  = (step_q == STEP_W'(SEQ_STEPS - 1)) ? '0 : step_q + STEP_W'(1);
	assign scene_nxt = (scene_q == SCENE_W'(SCENE_COUNT - 1)) ? '0 : scene_q + SCENE_W'(1);
	assign scene_sum = {1'b0, scene_acc_q} + (ACC_W+1)'(in_data.elapsed_us);
	assign step_due  = (step_acc_q >= (ACC_W+1)'(dur_q));
	assign pattern   = {pat_high_q, pat_low_q};

	// The tempo never leaves 45..220 BPM, but the duration still divides by
	// at least the lower bound.
	assign tempo_den = (tempo_q < TEMPO_MIN) ? TEMPO_MIN : tempo_q;

	// Tap tempo is round-to-nearest of 6e9*C / S, so half of S joins the
	// numerator before the division.
	assign tap_num = hist_num + NUM_W'(hist_sum >> 1);

	assign tap_q     = div_quot[TAP_Q_BITS-1:0];
	assign tempo_new = (tap_q < TAP_Q_BITS'(TEMPO_MIN)) ? TEMPO_MIN :
		(tap_q > TAP_Q_BITS'(TEMPO_MAX)) ? TEMPO_MAX : tap_q[TEMPO_W-1:0];

	// The divider starts with the high part of the numerator as its
	// remainder and shifts in only as many low bits as the quotient can have.
	always_comb begin
		if (div_tap_mode) begin
			div_rem_init = DIV_DEN_W'(tap_num[NUM_W-1:TAP_Q_BITS]);
			div_lo_init  = {tap_num[TAP_Q_BITS-1:0], {(DIV_LO_W-TAP_Q_BITS){1'b0}}};
			div_den      = DIV_DEN_W'(hist_sum);
		end else begin
			div_rem_init = DIV_DEN_W'(STEP_NUMER >> DUR_Q_BITS);
			div_lo_init  = STEP_NUMER[DUR_Q_BITS-1:0];
			div_den      = DIV_DEN_W'(tempo_den);
		end
	end

	tts_tap_hist #(
		.TAP_DEPTH(TAP_DEPTH)
	) u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (hist_push),
		.tap_time (in_data.tap_time_us),
		.sts      (hist_sts),
		.num      (hist_num),
		.sum      (hist_sum)
	);

	tts_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.rem_init (div_rem_init),
		.lo_init  (div_lo_init),
		.den      (div_den),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Control sequence. A tick walks the step loop one advance per cycle. A
	// tap pushes its time, scans the intervals, and only when one is valid
	// runs the tempo division followed by the step duration division.
	always_comb begin
		state_nxt    = state_q;
		in_stall     = 1'b1;
		hist_push    = 1'b0;
		div_tap_mode = 1'b0;
		div_req      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (in_data.req_type) begin
						hist_push = 1'b1;
						state_nxt = ST_SCAN;
					end else begin
						state_nxt = ST_TICK;
					end
				end
			end
			ST_TICK: begin
				if (!step_due) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (!hist_sts.busy) begin
					state_nxt = hist_sts.found ? ST_TDIV_GO : ST_FINISH;
				end
			end
			ST_TDIV_GO: begin
				div_tap_mode  = 1'b1;
				div_req.start = 1'b1;
				div_req.iters = DIV_CNT_W'(TAP_Q_BITS);
				state_nxt     = ST_TDIV_WAIT;
			end
			ST_TDIV_WAIT: begin
				if (!div_busy) begin
					state_nxt = ST_DDIV_GO;
				end
			end
			ST_DDIV_GO: begin
				div_req.start = 1'b1;
				div_req.iters = DIV_CNT_W'(DUR_Q_BITS);
				state_nxt     = ST_DDIV_WAIT;
			end
			ST_DDIV_WAIT: begin
				if (!div_busy) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Configuration registers take a write in any state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_en_q  <= 1'b0;
			period_q   <= SCENE_PERIOD_RESET;
			pat_low_q  <= '0;
			pat_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (tts_reg_t'(cfg_index))
				REG_AUTO_EN:  auto_en_q  <= cfg_data[0];
				REG_PERIOD:   period_q   <= cfg_data[ACC_W-1:0];
				REG_PAT_LOW:  pat_low_q  <= cfg_data;
				REG_PAT_HIGH: pat_high_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer state. On a tick transfer the running time, the step
	// accumulator and, with auto_en_q set, the scene accumulator take the
	// elapsed time at once; the scene decision is made there too (one add,
	// one compare). The step accumulator then loses one duration per cycle
	// in ST_TICK, ending below the duration, so 32 bits hold it at rest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_time_q  <= '0;
			step_acc_q  <= '0;
			scene_acc_q <= '0;
			step_q      <= '0;
			moved_q     <= 1'b0;
			scene_q     <= '0;
			level_q     <= '0;
			tempo_q     <= TEMPO_RESET;
			dur_q       <= DUR_RESET;
		end else begin
			if (in_fire) begin
				if (in_data.req_type) begin
					step_acc_q <= '0;
					step_q     <= '0;
				end else begin
					run_time_q <= run_time_q + TIME_W'(in_data.elapsed_us);
					step_acc_q <= step_acc_q + (ACC_W+1)'(in_data.elapsed_us);
					moved_q    <= 1'b0;
					if (auto_en_q) begin
						if (scene_sum >= (ACC_W+1)'(period_q)) begin
							scene_acc_q <= '0;
							scene_q     <= scene_nxt;
						end else begin
							scene_acc_q <= scene_sum[ACC_W-1:0];
						end
					end
				end
			end
			if ((state_q == ST_TICK) && step_due) begin
				step_acc_q <= step_acc_q - (ACC_W+1)'(dur_q);
				step_q     <= step_nxt;
				moved_q    <= 1'b1;
				level_q    <= pattern[{step_nxt, 3'b000} +: LEVEL_W];
			end
			if ((state_q == ST_TDIV_WAIT) && !div_busy) begin
				tempo_q <= tempo_new;
			end
			if ((state_q == ST_DDIV_WAIT) && !div_busy) begin
				dur_q <= div_quot[DUR_W-1:0];
			end
		end
	end

	// Result register. It frees the input side: the next item may be taken
	// while this result still waits for the downstream transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			out_q.step_index   <= step_q;
			out_q.step_moved   <= moved_q;
			out_q.glitch_level <= level_q;
			out_q.scene_index  <= scene_q;
			out_q.tempo_x100   <= tempo_q;
			out_q.run_time_us  <= run_time_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: hdl/tts_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module tts_serial_div
	import tts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  tts_div_req_t         req,
	input  logic [DIV_DEN_W-1:0] rem_init,
	input  logic [DIV_LO_W-1:0]  lo_init,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 busy,
	output logic [DIV_LO_W-1:0]  quot
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_LO_W-1:0]  lo_q;
	logic [DIV_LO_W-1:0]  quot_q;
	logic [DIV_DEN_W-1:0] den_q;

	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	// The caller preloads a remainder that is already below the divisor, so
	// each step brings in one numerator bit and makes one compare-subtract.
	assign trial = {rem_q, lo_q[DIV_LO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= rem_init;
			lo_q   <= lo_init;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			lo_q   <= {lo_q[DIV_LO_W-2:0], 1'b0};
			quot_q <= {quot_q[DIV_LO_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

// File: hdl/tts_tap_hist.sv
// Tap time history as a shift line, with a rotating scan of tap intervals.
module tts_tap_hist
	import tts_pkg::*;
#(
	parameter int TAP_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [TIME_W-1:0] tap_time,
	output tts_hist_sts_t     sts,
	output logic [NUM_W-1:0]  num,
	output logic [SUM_W-1:0]  sum
);

	localparam int CNT_W = $clog2(TAP_DEPTH + 1);
	localparam int IDX_W = $clog2(TAP_DEPTH);

	// Entry 0 is the newest tap. Only the first count entries were written.
	logic [TIME_W-1:0] hist_q [TAP_DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	logic              scan_q;
	logic              found_q;
	logic [SUM_W-1:0]  sum_q;
	logic [NUM_W-1:0]  num_q;

	logic [TIME_W-1:0] newer;
	logic [TIME_W-1:0] older;
	logic [TIME_W-1:0] gap;
	logic              pair_live;
	logic              take;

	assign newer     = hist_q[0];
	assign older     = hist_q[1];
	assign gap       = newer - older;
	assign pair_live = (CNT_W'(idx_q) + CNT_W'(1)) < count_q;
	assign take      = pair_live && (newer > older) && (gap > IVL_MIN) && (gap < IVL_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			scan_q  <= 1'b0;
			found_q <= 1'b0;
			sum_q   <= '0;
			num_q   <= '0;
		end else if (push) begin
			if (count_q != CNT_W'(TAP_DEPTH)) begin
				count_q <= count_q + CNT_W'(1);
			end
			idx_q   <= '0;
			scan_q  <= 1'b1;
			found_q <= 1'b0;
			sum_q   <= '0;
			num_q   <= '0;
		end else if (scan_q) begin
			if (take) begin
				found_q <= 1'b1;
				sum_q   <= sum_q + SUM_W'(gap);
				num_q   <= num_q + TAP_NUMER;
			end
			idx_q <= idx_q + IDX_W'(1);
			if (idx_q == IDX_W'(TAP_DEPTH - 1)) begin
				scan_q <= 1'b0;
			end
		end
	end

	// A push shifts the line toward the old end; a scan rotates it once round.
	always_ff @(posedge clk) begin
		if (push) begin
			hist_q[0] <= tap_time;
			for (int k = 1; k < TAP_DEPTH; k++) begin
				hist_q[k] <= hist_q[k-1];
			end
		end else if (scan_q) begin
			for (int k = 0; k < TAP_DEPTH; k++) begin
				hist_q[k] <= hist_q[(k + 1) % TAP_DEPTH];
			end
		end
	end

	assign sts.busy  = scan_q;
	assign sts.found = found_q;
	assign num       = num_q;
	assign sum       = sum_q;

endmodule

// File: hdl/tts_checker.sv
// Port-level checker for the tap tempo step sequencer, bound to its top level.
`include "assert_macros.svh"

module tts_checker
	import tts_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_stall,
	input logic     out_valid,
	input logic     out_stall,
	input tts_out_t out_data
);

	`TTS_ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, in_valid && !in_stall, in_stall, "input taken again right after a transfer")
	`TTS_ASSERT_SAME(a_tempo_range, clk, arst_n, out_valid, (out_data.tempo_x100 >= TEMPO_MIN) && (out_data.tempo_x100 <= TEMPO_MAX), "tempo outside its range")
	`TTS_ASSERT_SAME(a_scene_range, clk, arst_n, out_valid, out_data.scene_index <= SCENE_W'(SCENE_COUNT - 1), "scene index outside its range")
	`TTS_ASSERT_SAME(a_result_from_work, clk, arst_n, $rose(out_valid), $past(in_stall), "result appeared without work in progress")
	`TTS_ASSERT_NEXT(a_result_held, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind tap_tempo_step_sequencer_top tts_checker u_tts_checker (.*);
